>>> rtl/core/assert_macros.svh
// Assertion macros used by the exponentiator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/mexp_pkg.sv
// Shared constants and controller/datapath interface types for the modular exponentiator
package mexp_pkg;

	localparam int WORD_BITS_DEF = 31;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;      // capture a new item and arm the counters
		logic red_step;  // one restoring step of base mod modulus
		logic sq_load;   // set up acc * acc
		logic ml_load;   // set up base * acc
		logic mul_step;  // one double-and-add step of the modular product
		logic exp_next;  // advance to the next exponent bit
		logic out_load;  // move the final residue into the output register
	} mexp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic cnt_last;  // inner bit counter at its final step
		logic exp_bit;   // current exponent bit
		logic exp_last;  // last exponent bit processed
		logic out_free;  // output register can take a result this cycle
	} mexp_sts_t;

endpackage

>>> rtl/core/mexp_ctrl.sv
// Sequencing state machine for square-and-multiply exponentiation
module mexp_ctrl import mexp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  mexp_sts_t sts,
	output mexp_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_REDUCE   = 8'b0000_0010,
		S_SQ_LOAD  = 8'b0000_0100,
		S_SQ_RUN   = 8'b0000_1000,
		S_ML_LOAD  = 8'b0001_0000,
		S_ML_RUN   = 8'b0010_0000,
		S_EXP_NEXT = 8'b0100_0000,
		S_FINISH   = 8'b1000_0000
	} mexp_state_t;

	mexp_state_t state_q;
	mexp_state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_REDUCE;
				end
			end
			S_REDUCE: begin
				cmd.red_step = 1'b1;
				if (sts.cnt_last) begin
					state_d = S_SQ_LOAD;
				end
			end
			S_SQ_LOAD: begin
				cmd.sq_load = 1'b1;
				state_d     = S_SQ_RUN;
			end
			S_SQ_RUN: begin
				cmd.mul_step = 1'b1;
				if (sts.cnt_last) begin
					state_d = sts.exp_bit ? S_ML_LOAD : S_EXP_NEXT;
				end
			end
			S_ML_LOAD: begin
				cmd.ml_load = 1'b1;
				state_d     = S_ML_RUN;
			end
			S_ML_RUN: begin
				cmd.mul_step = 1'b1;
				if (sts.cnt_last) begin
					state_d = S_EXP_NEXT;
				end
			end
			S_EXP_NEXT: begin
				if (sts.exp_last) begin
					state_d = S_FINISH;
				end else begin
					cmd.exp_next = 1'b1;
					state_d      = S_SQ_LOAD;
				end
			end
			S_FINISH: begin
				// hold until the output register is free
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/mexp_datapath.sv
// Operand registers, bit-serial modular multiplier, base reducer and output register
module mexp_datapath import mexp_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mexp_cmd_t            cmd,
	output mexp_sts_t            sts,
	input  logic [WORD_BITS-1:0] modulus,
	input  logic [WORD_BITS-1:0] base_value,
	input  logic [WORD_BITS-1:0] exponent_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WORD_BITS-1:0] residue
);

	localparam int CW = $clog2(WORD_BITS);
	localparam logic [CW-1:0] CNT_TOP = CW'(WORD_BITS - 1);

	logic [WORD_BITS-1:0] base_sh_q;  // raw base, shifted out MSB first
	logic [WORD_BITS-1:0] rem_q;      // base mod modulus
	logic [WORD_BITS-1:0] exp_q;      // exponent, shifted out MSB first
	logic [WORD_BITS-1:0] acc_q;      // running power
	logic [WORD_BITS-1:0] mul_a_q;    // multiplicand
	logic [WORD_BITS-1:0] mul_b_q;    // multiplier, shifted out MSB first
	logic [WORD_BITS-1:0] prod_q;     // partial modular product
	logic [CW-1:0]        mcnt_q;
	logic [CW-1:0]        ecnt_q;
	logic [WORD_BITS-1:0] residue_q;
	logic                 out_valid_q;

	logic [WORD_BITS:0]   red_r;
	logic [WORD_BITS:0]   red_m;
	logic [WORD_BITS-1:0] red_next;
	logic [WORD_BITS+1:0] mul_t;
	logic [WORD_BITS+1:0] mul_m1;
	logic [WORD_BITS+1:0] mul_m2;
	logic [WORD_BITS+1:0] mul_sel;
	logic [WORD_BITS-1:0] prod_next;
	logic                 mod_is_one;
	logic                 mod_is_zero;

	assign mod_is_one  = (modulus == WORD_BITS'(1));
	assign mod_is_zero = (modulus == '0);

	// restoring remainder step: r < m keeps 2r+1 < 2m
	always_comb begin
		red_r = {rem_q, base_sh_q[WORD_BITS-1]};
		red_m = {1'b0, modulus};
		if (red_r >= red_m) begin
			red_next = WORD_BITS'(red_r - red_m);
		end else begin
			red_next = red_r[WORD_BITS-1:0];
		end
	end

	// double and conditionally add; sum stays below 3m, so at most one of two subtracts
	always_comb begin
		mul_t  = {1'b0, prod_q, 1'b0}
			+ {2'b00, (mul_b_q[WORD_BITS-1] ? mul_a_q : {WORD_BITS{1'b0}})};
		mul_m1 = {2'b00, modulus};
		mul_m2 = {1'b0, modulus, 1'b0};
		if (mul_t >= mul_m2) begin
			mul_sel = mul_t - mul_m2;
		end else if (mul_t >= mul_m1) begin
			mul_sel = mul_t - mul_m1;
		end else begin
			mul_sel = mul_t;
		end
		prod_next = mul_sel[WORD_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_sh_q <= base_value;
			exp_q     <= exponent_value;
			rem_q     <= '0;
			acc_q     <= mod_is_one ? '0 : WORD_BITS'(1);
		end else begin
			if (cmd.red_step) begin
				base_sh_q <= base_sh_q << 1;
				rem_q     <= red_next;
			end
			if (cmd.exp_next) begin
				exp_q <= exp_q << 1;
			end
			// take the product on the final multiplier step
			if (cmd.mul_step && (mcnt_q == '0)) begin
				acc_q <= prod_next;
			end
		end
		if (cmd.sq_load) begin
			mul_a_q <= acc_q;
			mul_b_q <= acc_q;
			prod_q  <= '0;
		end else if (cmd.ml_load) begin
			mul_a_q <= rem_q;
			mul_b_q <= acc_q;
			prod_q  <= '0;
		end else if (cmd.mul_step) begin
			mul_b_q <= mul_b_q << 1;
			prod_q  <= prod_next;
		end
		if (cmd.out_load) begin
			residue_q <= mod_is_zero ? '0 : acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q      <= '0;
			ecnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				mcnt_q <= CNT_TOP;
				ecnt_q <= CNT_TOP;
			end else begin
				if (cmd.sq_load || cmd.ml_load) begin
					mcnt_q <= CNT_TOP;
				end else if (cmd.red_step || cmd.mul_step) begin
					mcnt_q <= mcnt_q - CW'(1);
				end
				if (cmd.exp_next) begin
					ecnt_q <= ecnt_q - CW'(1);
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.cnt_last = (mcnt_q == '0);
	assign sts.exp_bit  = exp_q[WORD_BITS-1];
	assign sts.exp_last = (ecnt_q == '0);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign residue   = residue_q;

endmodule

>>> rtl/core/modular_exponentiation_top.sv
// Top level of the square-and-multiply modular exponentiator
// Computes residue = base_value ** exponent_value mod modulus on unsigned WORD_BITS-bit
// words. The base is first reduced by a restoring remainder unit (one bit a cycle), then
// every exponent bit, MSB first, squares the running power and, for a one bit, multiplies
// it by the reduced base; each modular product is built bit-serially by double-and-add,
// one multiplier bit a cycle; squaring and multiplying by the base both run on the single
// shared bit-serial multiplier. One item is in flight at a time; a finished result sits
// in the output register, so the next item is taken while it waits. An exponent of zero
// gives 1 (0 for a modulus of one); a modulus of zero gives 0. Write the modulus only
// while the block is idle; it resets to 2.
`include "assert_macros.svh"

module modular_exponentiation_top import mexp_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration: modulus register
	input  logic                 cfg_wr_en,
	input  logic [WORD_BITS-1:0] cfg_wr_data,
	// input transfer
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [WORD_BITS-1:0] base_value,
	input  logic [WORD_BITS-1:0] exponent_value,
	// output transfer
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WORD_BITS-1:0] residue
);

	logic [WORD_BITS-1:0] modulus_q;
	mexp_cmd_t            cmd;
	mexp_sts_t            sts;

	// modulus register; hold between writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= WORD_BITS'(2);
		end else if (cfg_wr_en) begin
			modulus_q <= cfg_wr_data;
		end
	end

	// sequencer: walk reduce, square, multiply and exponent-advance steps
	mexp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// operands, bit-serial arithmetic and the output register
	mexp_datapath #(
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.modulus        (modulus_q),
		.base_value     (base_value),
		.exponent_value (exponent_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.residue        (residue)
	);

	// an accepted item keeps the input closed while it is worked on
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// never overwrite a result that is still stalled at the output
	`ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, cmd.out_load, !(out_valid && out_stall))
	// every delivered residue is fully reduced
	`ASSERT_IMPLIES(a_residue_reduced, clk, arst_n, out_valid && (modulus_q != '0),
		residue < modulus_q)

endmodule

>>> bench/modular_exponentiation_checker.sv
// Transfer monitor, residue predictor and scoreboard for the modular exponentiator
`timescale 1ns / 1ps

module modular_exponentiation_checker import mexp_pkg::*; #(
	parameter int W = WORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [W-1:0] cfg_wr_data,
	input  logic         in_valid,
	input  logic         in_stall,
	input  logic [W-1:0] base_value,
	input  logic [W-1:0] exponent_value,
	input  logic         out_valid,
	input  logic         out_stall,
	input  logic [W-1:0] residue,
	output int           mismatch_count,
	output int           pending_results
);

	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [W-1:0] base;
		logic [W-1:0] expo;
		logic [W-1:0] modulus;
		logic [W-1:0] residue;
	} residue_entry_t;

	residue_entry_t residue_queue[$];
	logic [W-1:0]   modulus_copy;

	// Square and multiply, MSB first; 64-bit products of reduced words stay exact
	function automatic logic [W-1:0] power_mod(input logic [W-1:0] base,
			input logic [W-1:0] expo, input logic [W-1:0] modulus);
		longint unsigned m;
		longint unsigned b;
		longint unsigned acc;
		if (modulus == '0)
			return '0;
		m   = modulus;
		b   = base % m;
		acc = 64'd1 % m;
		for (int i = W - 1; i >= 0; i--) begin
			acc = (acc * acc) % m;
			if (expo[i])
				acc = (acc * b) % m;
		end
		return acc[W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		residue_entry_t entry;
		if (!arst_n) begin
			modulus_copy = W'(2);
			residue_queue.delete();
			mismatch_count  = 0;
			pending_results = 0;
		end else begin
			// retire the oldest expectation before queuing a new one
			if (out_valid && !out_stall) begin
				if (residue_queue.size() == 0) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("%0t: residue %0d with no item outstanding", $time, residue);
					mismatch_count++;
				end else begin
					entry = residue_queue.pop_front();
					if (residue !== entry.residue) begin
						if (mismatch_count < REPORT_LIMIT)
							$display("%0t: residue mismatch for %0d ** %0d mod %0d: expected %0d, got %0d",
								$time, entry.base, entry.expo, entry.modulus,
								entry.residue, residue);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				entry.base    = base_value;
				entry.expo    = exponent_value;
				entry.modulus = modulus_copy;
				entry.residue = power_mod(base_value, exponent_value, modulus_copy);
				residue_queue.push_back(entry);
			end
			if (cfg_wr_en)
				modulus_copy = cfg_wr_data;
			pending_results = residue_queue.size();
		end
	end

endmodule

>>> bench/modular_exponentiation_top_tb.sv
// Stimulus, flow control and verdict for the modular exponentiator testbench
`timescale 1ns / 1ps

module modular_exponentiation_top_tb import mexp_pkg::*;;

	localparam int           W            = WORD_BITS_DEF;
	localparam logic [W-1:0] WORD_MAX     = '1;
	// long enough for a late or extra result to show up
	localparam int           DRAIN_CYCLES = 2200;
	// long enough for one item in flight plus one parked result to back up the input
	localparam int           HOLD_CYCLES  = 8000;
	localparam int           PHASE_ITEMS  = 30;

	logic         clk            = 1'b0;
	logic         arst_n         = 1'b0;
	logic         cfg_wr_en      = 1'b0;
	logic [W-1:0] cfg_wr_data    = '0;
	logic         in_valid       = 1'b0;
	logic         in_stall;
	logic [W-1:0] base_value     = '0;
	logic [W-1:0] exponent_value = '0;
	logic         out_valid;
	logic         out_stall      = 1'b0;
	logic [W-1:0] residue;

	int mismatch_count;
	int pending_results;

	// Flow control knobs: 0 disables idling, N starts a burst on roughly one draw in N
	int           sender_gap_odds   = 4;
	int           receiver_gap_odds = 4;
	bit           long_hold_go      = 1'b0;
	logic [W-1:0] modulus_now       = W'(2);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	modular_exponentiation_top #(.WORD_BITS(W)) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.base_value     (base_value),
		.exponent_value (exponent_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.residue        (residue)
	);

	modular_exponentiation_checker #(.W(W)) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.base_value      (base_value),
		.exponent_value  (exponent_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.residue         (residue),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	// Offer one input transfer, optionally after an idle burst, and hold it until taken.
	// Leave in_valid high on return so back-to-back transfers need no extra edge.
	task automatic send_item(input logic [W-1:0] base, input logic [W-1:0] expo);
		int gap;
		if (sender_gap_odds != 0 && $urandom_range(0, sender_gap_odds - 1) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 7);
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		base_value     <= base;
		exponent_value <= expo;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and wait at a falling edge until every expected residue has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_results != 0);
	endtask

	// Write the modulus only once the block holds nothing
	task automatic set_modulus(input logic [W-1:0] value);
		wait_drained();
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		modulus_now  = value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Bias bases toward the modulus boundaries, keep the rest uniform
	function automatic logic [W-1:0] pick_base(input logic [W-1:0] m);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return W'(1);
			2:       return m - W'(1);
			3:       return m;
			4:       return m + W'(1);
			5:       return WORD_MAX;
			6, 7:    return W'($urandom);
			default: return (m == '0) ? W'($urandom) : W'($urandom_range(0, m - 1));
		endcase
	endfunction

	// Mix short, sparse, dense and Fermat-style exponents
	function automatic logic [W-1:0] pick_exponent(input logic [W-1:0] m);
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return W'(1);
			2:       return W'(2);
			3:       return WORD_MAX;
			4:       return m - W'(1);
			5:       return W'($urandom_range(0, 64));
			6:       return W'($urandom & $urandom);
			7:       return W'($urandom | $urandom);
			default: return W'($urandom);
		endcase
	endfunction

	// Receiver: random stall bursts, plus one long hold-off counted here in cycles
	initial begin
		int burst;
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_go && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				out_stall <= 1'b0;
			end else if (receiver_gap_odds != 0
					&& $urandom_range(0, receiver_gap_odds - 1) == 0) begin
				out_stall <= 1'b1;
				burst = $urandom_range(1, 7);
				repeat (burst) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [W-1:0] phase_modulus[9];
		int           odds_pick[3];
		odds_pick = '{0, 4, 16};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset modulus of 2: everything collapses to 0 or 1
		send_item('0, '0);
		send_item(WORD_MAX, WORD_MAX);
		send_item(W'(2), W'(5));
		send_item(WORD_MAX, '0);

		// Largest modulus, a prime: zero exponent, zero base, base equal to the modulus,
		// base of minus one, powers of two at the word edge, and Fermat's little theorem
		set_modulus(WORD_MAX);
		send_item('0, '0);
		send_item('0, W'(5));
		send_item(WORD_MAX, W'(1));
		send_item(WORD_MAX - W'(1), W'(2));
		send_item(W'(2), W'(30));
		send_item(W'(2), W'(31));
		send_item(W'(3), WORD_MAX - W'(1));
		send_item(W'(12345), WORD_MAX);
		send_item(W'(1), WORD_MAX);
		send_item(W'(5), '0);

		// Modulus of one: every residue is 0, even for a zero exponent
		set_modulus(W'(1));
		send_item(W'(7), '0);
		send_item('0, '0);
		send_item(WORD_MAX, WORD_MAX);

		// Modulus of zero: no reduction, residue forced to 0
		set_modulus('0);
		send_item(W'(7), '0);
		send_item(W'(5), W'(5));
		send_item(WORD_MAX, WORD_MAX);

		// Random phases over a spread of moduli
		phase_modulus[0] = WORD_MAX;
		phase_modulus[1] = W'(3);
		phase_modulus[2] = W'(65537);
		phase_modulus[3] = W'($urandom) | (W'(1) << (W - 1));
		phase_modulus[4] = W'($urandom_range(2, 1000));
		phase_modulus[5] = WORD_MAX - W'(1);
		phase_modulus[6] = W'(1) << (W - 1);
		phase_modulus[7] = W'($urandom_range(2, 32'h7fff_ffff));
		phase_modulus[8] = W'(2);

		for (int ph = 0; ph < 9; ph++) begin
			set_modulus(phase_modulus[ph]);
			if (ph == 8) begin
				// final stretch runs flat out on both sides
				sender_gap_odds   = 0;
				receiver_gap_odds = 0;
			end else begin
				sender_gap_odds   = odds_pick[$urandom_range(0, 2)];
				receiver_gap_odds = odds_pick[$urandom_range(0, 2)];
			end
			// back up the block: the receiver holds off while items keep coming
			if (ph == 2)
				long_hold_go = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_item(pick_base(modulus_now), pick_exponent(modulus_now));
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatch_count == 0 && pending_results == 0) begin
			$display("modular_exponentiation_top_tb passed");
		end else begin
			$display("modular_exponentiation_top_tb failed");
		end
		$finish;
	end

	// Watchdog: several times the slowest legal run
	initial begin
		#20_000_000;
		$display("modular_exponentiation_top_tb failed");
		$finish;
	end

endmodule
